>>> rtl/mpic_pkg.sv
`timescale 1ns / 1ps
package mpic_pkg;

   localparam int NUM_LINES  = 32;
   localparam int LINE_COUNT = (NUM_LINES > 32) ? 32 : NUM_LINES;
   localparam int WORD_W     = 32;
   localparam int NUM_W      = 5;

   typedef enum logic [1:0] {
      REQ_ASSERT   = 2'd0,
      REQ_DEASSERT = 2'd1,
      REQ_READ     = 2'd2,
      REQ_WRITE    = 2'd3
   } req_kind_type;

   localparam logic [7:0] OFS_MASK     = 8'd0;
   localparam logic [7:0] OFS_MASK_SET = 8'd4;
   localparam logic [7:0] OFS_MASK_CLR = 8'd8;
   localparam logic [7:0] OFS_STAT     = 8'd12;
   localparam logic [7:0] OFS_CUR_BIT  = 8'd16;
   localparam logic [7:0] OFS_CUR_NUM  = 8'd20;

   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic              any;
      logic [WORD_W-1:0] onehot;
      logic [NUM_W-1:0]  num;
   } prio_type;

endpackage

>>> rtl/mpic_if.sv
`timescale 1ns / 1ps
interface mpic_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] vector;
   logic [7:0] reg_offset;
   logic [2:0] access_size;
   logic [31:0] write_data;

   modport source (output valid, req_type, vector, reg_offset, access_size, write_data,
                   input ready);
   modport sink   (input valid, req_type, vector, reg_offset, access_size, write_data,
                   output ready);
endinterface

interface mpic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        status;
   logic        irq_out;

   modport source (output valid, read_data, status, irq_out, input ready);
   modport sink   (input valid, read_data, status, irq_out, output ready);
endinterface

>>> rtl/mpic_prio.sv
`timescale 1ns / 1ps
module mpic_prio import mpic_pkg::*; (
   input  logic [WORD_W-1:0] pending,
   output prio_type          prio
);

   logic [WORD_W-1:0] lowest;
   logic [NUM_W-1:0]  num;

   // isolate lowest set bit, then encode its position
   assign lowest = pending & (~pending + WORD_W'(1));

   always_comb begin
      num = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lowest[i]) begin
            num = num | NUM_W'(i);
         end
      end
   end

   assign prio.any    = |pending;
   assign prio.onehot = lowest;
   assign prio.num    = num;

endmodule

>>> rtl/masked_priority_interrupt_controller.sv
`timescale 1ns / 1ps
// Path: a request passes the input register, then the result register, before its
// result is offered on rsp_chan.
// Throughput: one request per cycle; while a result waits for the sink the
// input register takes one more request, then the input stalls.
// Reset (synchronous): mask and active lines cleared, both stages emptied.
module masked_priority_interrupt_controller import mpic_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mpic_req_if.sink   req_chan,
   mpic_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   req_kind_type      in_kind_ff;
   logic [7:0]        in_vector_ff;
   logic [7:0]        in_offset_ff;
   logic [2:0]        in_size_ff;
   logic [WORD_W-1:0] in_data_ff;

   logic              out_valid_ff;
   logic [WORD_W-1:0] out_read_ff;
   logic              out_status_ff;
   logic              out_irq_ff;

   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] active_ff, active_in;
   logic [WORD_W-1:0] read_in;
   logic              status_in;
   logic              irq_in;

   logic              advance;
   logic              vec_ok;
   logic              word_acc;
   logic [WORD_W-1:0] line_bit;
   prio_type          prio;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   mpic_prio u_prio (
      .pending (active_ff & ~mask_ff),
      .prio    (prio)
   );

   assign vec_ok   = in_vector_ff < 8'(LINE_COUNT);
   assign word_acc = in_size_ff[2];
   assign line_bit = WORD_W'(1) << in_vector_ff[NUM_W-1:0];

   always_comb begin
      mask_in   = mask_ff;
      active_in = active_ff;
      read_in   = '0;
      status_in = 1'b0;
      case (in_kind_ff)
         REQ_ASSERT, REQ_DEASSERT: begin
            if (!vec_ok) begin
               status_in = 1'b1;
            end else if (in_kind_ff == REQ_ASSERT) begin
               active_in = active_ff | line_bit;
            end else begin
               active_in = active_ff & ~line_bit;
            end
         end
         REQ_READ, REQ_WRITE: begin
            if (word_acc) begin
               case (in_offset_ff)
                  OFS_MASK: begin
                     if (in_kind_ff == REQ_WRITE) mask_in = in_data_ff;
                     else read_in = mask_ff;
                  end
                  OFS_MASK_SET: begin
                     if (in_kind_ff == REQ_WRITE) mask_in = mask_ff | in_data_ff;
                     else read_in = mask_ff;
                  end
                  OFS_MASK_CLR: begin
                     if (in_kind_ff == REQ_WRITE) mask_in = mask_ff & ~in_data_ff;
                     else read_in = mask_ff;
                  end
                  OFS_STAT:    read_in = active_ff;
                  OFS_CUR_BIT: read_in = prio.onehot;
                  OFS_CUR_NUM: read_in = prio.any ? WORD_W'(prio.num) : ALL_ONES;
                  default:     read_in = '0;
               endcase
            end
         end
         default: begin
            read_in = '0;
         end
      endcase
      irq_in = |(active_in & ~mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= '0;
         active_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mask_ff      <= mask_in;
            active_ff    <= active_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_kind_ff   <= req_kind_type'(req_chan.req_type);
         in_vector_ff <= req_chan.vector;
         in_offset_ff <= req_chan.reg_offset;
         in_size_ff   <= req_chan.access_size;
         in_data_ff   <= req_chan.write_data;
      end
      if (advance) begin
         out_read_ff   <= read_in;
         out_status_ff <= status_in;
         out_irq_ff    <= irq_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_read_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.irq_out   = out_irq_ff;

endmodule
